>>> sv/lba_pkg.sv
package lba_pkg;

  typedef enum logic [2:0] {
    FN_FORMAT    = 3'd0,
    FN_CREATE    = 3'd1,
    FN_DELETE    = 3'd2,
    FN_APPEND    = 3'd3,
    FN_DEFRAG    = 3'd4,
    FN_READ_SLOT = 3'd5,
    FN_READ_LINK = 3'd6,
    FN_NOP       = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_SHORT     = 3'd3,
    ST_FULL      = 3'd4
  } st_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_FORMAT,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_ALLOC_INIT,
    OP_ALLOC_STEP,
    OP_ALLOC_END,
    OP_CREATE_WR,
    OP_APPEND_WR,
    OP_WALK_INIT,
    OP_WALK_RD,
    OP_WALK_NXT,
    OP_WALK_END,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_DEL_END,
    OP_PACK_INIT,
    OP_PACK_CAP,
    OP_PACK_SKIP,
    OP_PACK_STEP,
    OP_PACK_WR,
    OP_SLOT_RD,
    OP_LINK_RD,
    OP_FINISH,
    OP_FINISH_SLOT,
    OP_FINISH_LINK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    st_t    st;
  } lba_cmd_t;

  typedef struct packed {
    func_t func;
    logic  scan_end;
    logic  match;
    logic  full;
    logic  cnt_zero;
    logic  short_blk;
    logic  alloc_done;
    logic  walk_done;
    logic  shift_done;
    logic  pack_fit;
    logic  pack_blk_done;
    logic  slot_ok;
    logic  link_ok;
    logic  out_free;
  } lba_sts_t;

  // Value of total_blocks after reset.
  localparam logic [8:0] TOTAL_RST = 9'd256;

endpackage

>>> sv/linked_block_allocator.sv
// Format, no-op and reads load the command, dispatch it and then present the result.
// Create/append search the file table entry by entry, then scan the block store for free
// blocks. Delete searches the table, frees each block of the file and moves every later
// table entry down by one. Defrag packs the blocks of each file that fits, in table order,
// from block 0. The table and link memories are single-port. One command at a time.
// Reset (rst_n low, synchronous) empties the store: no files, all blocks free.
module linked_block_allocator #(
  parameter int BLOCK_SLOTS = 256,
  parameter int FILE_SLOTS  = 128,
  parameter int NAME_CHARS  = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [63:0]        in_name_low,
  input  logic [15:0]        in_name_high,
  input  logic [8:0]         in_block_count,
  input  logic [7:0]         in_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [7:0]         out_files_in_use,
  output logic [8:0]         out_free_blocks,
  output logic [63:0]        out_slot_name_low,
  output logic [15:0]        out_slot_name_high,
  output logic signed [8:0]  out_head_block,
  output logic signed [8:0]  out_tail_block,
  output logic [8:0]         out_blocks_held,
  output logic signed [8:0]  out_link,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data
);

  lba_pkg::lba_cmd_t cmd;
  lba_pkg::lba_sts_t sts;

  lba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lba_dp #(
    .BLOCK_SLOTS (BLOCK_SLOTS),
    .FILE_SLOTS  (FILE_SLOTS),
    .NAME_CHARS  (NAME_CHARS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_name_low        (in_name_low),
    .in_name_high       (in_name_high),
    .in_block_count     (in_block_count),
    .in_index           (in_index),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_files_in_use   (out_files_in_use),
    .out_free_blocks    (out_free_blocks),
    .out_slot_name_low  (out_slot_name_low),
    .out_slot_name_high (out_slot_name_high),
    .out_head_block     (out_head_block),
    .out_tail_block     (out_tail_block),
    .out_blocks_held    (out_blocks_held),
    .out_link           (out_link)
  );

endmodule

>>> sv/lba_dp.sv
module lba_dp #(
  parameter int BLOCK_SLOTS = 256,
  parameter int FILE_SLOTS  = 128,
  parameter int NAME_CHARS  = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lba_pkg::lba_cmd_t   cmd,
  output lba_pkg::lba_sts_t   sts,
  input  logic [2:0]          in_func,
  input  logic [63:0]         in_name_low,
  input  logic [15:0]         in_name_high,
  input  logic [8:0]          in_block_count,
  input  logic [7:0]          in_index,
  input  logic                cfg_wr_en,
  input  logic [8:0]          cfg_wr_data,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [7:0]          out_files_in_use,
  output logic [8:0]          out_free_blocks,
  output logic [63:0]         out_slot_name_low,
  output logic [15:0]         out_slot_name_high,
  output logic signed [8:0]   out_head_block,
  output logic signed [8:0]   out_tail_block,
  output logic [8:0]          out_blocks_held,
  output logic signed [8:0]   out_link
);

  localparam int BW  = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int FW  = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int BVW = BW + 1;
  localparam int CW  = $clog2(BLOCK_SLOTS + 1);
  localparam int FCW = $clog2(FILE_SLOTS + 1);
  localparam int IW  = $clog2(((BLOCK_SLOTS > FILE_SLOTS) ? BLOCK_SLOTS : FILE_SLOTS) + 1);
  localparam int HI_SH = 8 * ((NAME_CHARS > 8) ? (NAME_CHARS - 8) : 0);
  localparam logic [63:0] LO_MASK = (NAME_CHARS >= 8) ? {64{1'b1}}
                                  : ((64'd1 << (8 * NAME_CHARS)) - 64'd1);
  localparam logic [15:0] HI_MASK = (NAME_CHARS >= 10) ? {16{1'b1}}
                                  : (NAME_CHARS <= 8) ? 16'd0
                                  : ((16'd1 << HI_SH) - 16'd1);
  localparam int FREE_RST_I = (BLOCK_SLOTS < int'(lba_pkg::TOTAL_RST)) ? BLOCK_SLOTS
                            : int'(lba_pkg::TOTAL_RST);
  localparam logic [CW-1:0] FREE_RST = CW'(FREE_RST_I);
  localparam logic signed [BVW-1:0] NO_BLK = '1;

  typedef struct packed {
    logic [63:0]            lo;
    logic [15:0]            hi;
    logic signed [BVW-1:0]  head;
    logic signed [BVW-1:0]  tail;
    logic [CW-1:0]          cnt;
  } tbl_ent_t;

  tbl_ent_t tbl_mem [FILE_SLOTS];
  logic signed [BVW-1:0] link_mem [BLOCK_SLOTS];

  lba_pkg::func_t        func_r;
  logic [63:0]           lo_r;
  logic [15:0]           hi_r;
  logic [8:0]            cnt_r;
  logic [7:0]            idx_r;
  logic [IW-1:0]         i_r;
  logic [FW-1:0]         s_r;
  logic [CW-1:0]         k_r;
  logic [CW-1:0]         pos_r;
  logic [CW-1:0]         got_r;
  logic signed [BVW-1:0] prev_r;
  logic signed [BVW-1:0] first_r;
  logic signed [BVW-1:0] blk_r;
  tbl_ent_t              ent_r;
  tbl_ent_t              tbl_rd_r;
  logic signed [BVW-1:0] link_rd_r;
  logic                  link_used_r;
  logic [BLOCK_SLOTS-1:0] used_r;
  logic [FCW-1:0]        files_r;
  logic [CW-1:0]         free_r;
  logic [8:0]            tb_r;
  logic                  out_valid_r;

  logic                  tbl_re, tbl_we, link_re, link_we;
  logic [FW-1:0]         tbl_ra, tbl_wa;
  tbl_ent_t              tbl_wd;
  logic [BW-1:0]         link_ra, link_wa;
  logic signed [BVW-1:0] link_wd;
  logic signed [BVW-1:0] link_q;
  logic signed [BVW-1:0] i_blk;
  logic                  free_blk;
  logic                  match;
  logic                  app_new_head;
  logic                  finishing;
  logic [CW-1:0]         free_fmt;

  assign link_q       = link_used_r ? link_rd_r : NO_BLK;
  assign i_blk        = signed'(BVW'(i_r));
  assign free_blk     = !used_r[i_r[BW-1:0]];
  assign match        = (tbl_rd_r.lo == lo_r) && (tbl_rd_r.hi == hi_r);
  assign app_new_head = (ent_r.cnt == '0) || ent_r.tail[BVW-1];
  assign finishing    = (cmd.op == lba_pkg::OP_FINISH) || (cmd.op == lba_pkg::OP_FINISH_SLOT)
                     || (cmd.op == lba_pkg::OP_FINISH_LINK);
  assign free_fmt     = (32'(tb_r) < BLOCK_SLOTS) ? CW'(tb_r) : CW'(BLOCK_SLOTS);

  always_comb begin
    sts.func          = func_r;
    sts.scan_end      = 32'(i_r) >= 32'(files_r);
    sts.match         = match;
    sts.full          = 32'(files_r) >= FILE_SLOTS;
    sts.cnt_zero      = (cnt_r == 9'd0);
    sts.short_blk     = 32'(cnt_r) > 32'(free_r);
    sts.alloc_done    = (32'(got_r) >= 32'(cnt_r)) || (32'(i_r) >= BLOCK_SLOTS);
    sts.walk_done     = !((32'(k_r) < 32'(ent_r.cnt)) && !blk_r[BVW-1]);
    sts.shift_done    = (32'(i_r) + 32'd1) >= 32'(files_r);
    sts.pack_fit      = (ent_r.cnt != '0) && ((32'(pos_r) + 32'(ent_r.cnt)) <= BLOCK_SLOTS);
    sts.pack_blk_done = 32'(k_r) >= 32'(ent_r.cnt);
    sts.slot_ok       = 32'(idx_r) < 32'(files_r);
    sts.link_ok       = 32'(idx_r) < BLOCK_SLOTS;
    sts.out_free      = !out_valid_r || !out_stall;
  end

  // Memory port control.
  always_comb begin
    tbl_re  = 1'b0;
    tbl_ra  = i_r[FW-1:0];
    tbl_we  = 1'b0;
    tbl_wa  = i_r[FW-1:0];
    tbl_wd  = tbl_rd_r;
    link_re = 1'b0;
    link_ra = blk_r[BW-1:0];
    link_we = 1'b0;
    link_wa = prev_r[BW-1:0];
    link_wd = NO_BLK;
    unique case (cmd.op)
      lba_pkg::OP_SCAN_RD: begin
        tbl_re = 1'b1;
      end
      lba_pkg::OP_SHIFT_RD: begin
        tbl_re = 1'b1;
        tbl_ra = FW'(i_r + 1'b1);
      end
      lba_pkg::OP_SLOT_RD: begin
        tbl_re = 1'b1;
        tbl_ra = FW'(idx_r);
      end
      lba_pkg::OP_SHIFT_WR: begin
        tbl_we = 1'b1;
      end
      lba_pkg::OP_CREATE_WR: begin
        tbl_we = 1'b1;
        tbl_wa = FW'(files_r);
        tbl_wd = '{lo: lo_r, hi: hi_r, head: first_r, tail: prev_r, cnt: CW'(cnt_r)};
      end
      lba_pkg::OP_APPEND_WR: begin
        tbl_we  = 1'b1;
        tbl_wa  = s_r;
        tbl_wd  = '{lo: ent_r.lo, hi: ent_r.hi,
                    head: app_new_head ? first_r : ent_r.head,
                    tail: prev_r, cnt: ent_r.cnt + CW'(cnt_r)};
        link_we = !app_new_head;
        link_wa = ent_r.tail[BW-1:0];
        link_wd = first_r;
      end
      lba_pkg::OP_PACK_SKIP: begin
        tbl_we = 1'b1;
        tbl_wd = '{lo: ent_r.lo, hi: ent_r.hi, head: NO_BLK, tail: NO_BLK, cnt: ent_r.cnt};
      end
      lba_pkg::OP_PACK_WR: begin
        tbl_we = 1'b1;
        tbl_wd = '{lo: ent_r.lo, hi: ent_r.hi,
                   head: signed'(BVW'(pos_r - ent_r.cnt)),
                   tail: signed'(BVW'(pos_r - 1'b1)), cnt: ent_r.cnt};
      end
      lba_pkg::OP_ALLOC_STEP: begin
        link_we = free_blk && !prev_r[BVW-1];
        link_wd = i_blk;
      end
      lba_pkg::OP_ALLOC_END: begin
        link_we = !prev_r[BVW-1];
      end
      lba_pkg::OP_PACK_STEP: begin
        link_we = 1'b1;
        link_wa = pos_r[BW-1:0];
        link_wd = ((32'(k_r) + 32'd1) < 32'(ent_r.cnt)) ? signed'(BVW'(pos_r + 1'b1))
                                                        : NO_BLK;
      end
      lba_pkg::OP_WALK_RD: begin
        link_re = 1'b1;
      end
      lba_pkg::OP_LINK_RD: begin
        link_re = 1'b1;
        link_ra = BW'(idx_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_rd_r <= tbl_mem[tbl_ra];
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    // A link only means something while its block is in use.
    if (link_re) begin
      link_rd_r   <= link_mem[link_ra];
      link_used_r <= used_r[link_ra];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      lba_pkg::OP_LOAD: begin
        func_r <= lba_pkg::func_t'(in_func);
        lo_r   <= in_name_low & LO_MASK;
        hi_r   <= in_name_high & HI_MASK;
        cnt_r  <= in_block_count;
        idx_r  <= in_index;
      end
      lba_pkg::OP_SCAN_INIT: begin
        i_r <= '0;
      end
      lba_pkg::OP_SCAN_CHK: begin
        ent_r <= tbl_rd_r;
        s_r   <= i_r[FW-1:0];
        if (!match) begin
          i_r <= i_r + 1'b1;
        end
      end
      lba_pkg::OP_ALLOC_INIT: begin
        i_r     <= '0;
        got_r   <= '0;
        prev_r  <= NO_BLK;
        first_r <= NO_BLK;
      end
      lba_pkg::OP_ALLOC_STEP: begin
        if (free_blk) begin
          if (prev_r[BVW-1]) begin
            first_r <= i_blk;
          end
          prev_r <= i_blk;
          got_r  <= got_r + 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
      lba_pkg::OP_WALK_INIT: begin
        blk_r <= ent_r.head;
        k_r   <= '0;
      end
      lba_pkg::OP_WALK_RD: begin
        k_r <= k_r + 1'b1;
      end
      lba_pkg::OP_WALK_NXT: begin
        blk_r <= link_q;
      end
      lba_pkg::OP_WALK_END: begin
        i_r <= IW'(s_r);
      end
      lba_pkg::OP_SHIFT_WR, lba_pkg::OP_PACK_SKIP, lba_pkg::OP_PACK_WR: begin
        i_r <= i_r + 1'b1;
      end
      lba_pkg::OP_PACK_INIT: begin
        i_r   <= '0;
        pos_r <= '0;
      end
      lba_pkg::OP_PACK_CAP: begin
        ent_r <= tbl_rd_r;
        k_r   <= '0;
      end
      lba_pkg::OP_PACK_STEP: begin
        pos_r <= pos_r + 1'b1;
        k_r   <= k_r + 1'b1;
      end
      lba_pkg::OP_FINISH, lba_pkg::OP_FINISH_SLOT, lba_pkg::OP_FINISH_LINK: begin
        out_status         <= cmd.st;
        out_files_in_use   <= 8'(files_r);
        out_free_blocks    <= 9'(free_r);
        out_slot_name_low  <= '0;
        out_slot_name_high <= '0;
        out_head_block     <= '0;
        out_tail_block     <= '0;
        out_blocks_held    <= '0;
        out_link           <= '0;
        if (cmd.op == lba_pkg::OP_FINISH_SLOT) begin
          if (cmd.st == lba_pkg::ST_OK) begin
            out_slot_name_low  <= tbl_rd_r.lo;
            out_slot_name_high <= tbl_rd_r.hi;
            out_head_block     <= (tbl_rd_r.cnt != '0) ? 9'(tbl_rd_r.head) : 9'(NO_BLK);
            out_tail_block     <= (tbl_rd_r.cnt != '0) ? 9'(tbl_rd_r.tail) : 9'(NO_BLK);
            out_blocks_held    <= 9'(tbl_rd_r.cnt);
          end else begin
            out_head_block <= 9'(NO_BLK);
            out_tail_block <= 9'(NO_BLK);
          end
        end
        if (cmd.op == lba_pkg::OP_FINISH_LINK) begin
          out_link <= (cmd.st == lba_pkg::ST_OK) ? 9'(link_q) : 9'(NO_BLK);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      files_r     <= '0;
      free_r      <= FREE_RST;
      tb_r        <= lba_pkg::TOTAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tb_r <= cfg_wr_data;
      end
      if (finishing) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        lba_pkg::OP_FORMAT: begin
          used_r  <= '0;
          files_r <= '0;
          free_r  <= free_fmt;
        end
        lba_pkg::OP_ALLOC_STEP: begin
          if (free_blk) begin
            used_r[i_r[BW-1:0]] <= 1'b1;
          end
        end
        lba_pkg::OP_ALLOC_END: begin
          free_r <= free_r - got_r;
        end
        lba_pkg::OP_CREATE_WR: begin
          files_r <= files_r + 1'b1;
        end
        lba_pkg::OP_WALK_RD: begin
          used_r[blk_r[BW-1:0]] <= 1'b0;
        end
        lba_pkg::OP_WALK_END: begin
          free_r <= free_r + ent_r.cnt;
        end
        lba_pkg::OP_DEL_END: begin
          files_r <= files_r - 1'b1;
        end
        lba_pkg::OP_PACK_INIT: begin
          used_r <= '0;
        end
        lba_pkg::OP_PACK_STEP: begin
          used_r[pos_r[BW-1:0]] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_files_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(files_r) <= FILE_SLOTS)
    else $error("file count beyond table size");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_r) <= BLOCK_SLOTS)
    else $error("free count beyond block store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    finishing |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transfer");

endmodule

>>> sv/lba_ctrl.sv
module lba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lba_pkg::lba_sts_t  sts,
  output lba_pkg::lba_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_FIND, S_CMP, S_CREATE, S_APPEND, S_ALLOC, S_ALLOC_WR,
    S_WALK0, S_WALK, S_WALK_NXT, S_SHIFT, S_SHIFT_WR, S_PACK, S_PACK_CAP,
    S_PACK_FIT, S_PACK_BLK, S_FIN, S_FIN_SLOT, S_FIN_LINK
  } state_t;

  state_t          state_r, state_nxt;
  lba_pkg::st_t    st_r, st_nxt;
  lba_pkg::dp_op_t op;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    op        = lba_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = lba_pkg::OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_nxt = lba_pkg::ST_OK;
        unique case (sts.func)
          lba_pkg::FN_FORMAT: begin
            op        = lba_pkg::OP_FORMAT;
            state_nxt = S_FIN;
          end
          lba_pkg::FN_CREATE, lba_pkg::FN_DELETE, lba_pkg::FN_APPEND: begin
            op        = lba_pkg::OP_SCAN_INIT;
            state_nxt = S_FIND;
          end
          lba_pkg::FN_DEFRAG: begin
            op        = lba_pkg::OP_PACK_INIT;
            state_nxt = S_PACK;
          end
          lba_pkg::FN_READ_SLOT: begin
            op        = lba_pkg::OP_SLOT_RD;
            st_nxt    = sts.slot_ok ? lba_pkg::ST_OK : lba_pkg::ST_NOT_FOUND;
            state_nxt = S_FIN_SLOT;
          end
          lba_pkg::FN_READ_LINK: begin
            op        = lba_pkg::OP_LINK_RD;
            st_nxt    = sts.link_ok ? lba_pkg::ST_OK : lba_pkg::ST_NOT_FOUND;
            state_nxt = S_FIN_LINK;
          end
          lba_pkg::FN_NOP: begin
            state_nxt = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_FIND: begin
        if (sts.scan_end) begin
          if (sts.func == lba_pkg::FN_CREATE) begin
            state_nxt = S_CREATE;
          end else begin
            st_nxt    = lba_pkg::ST_NOT_FOUND;
            state_nxt = S_FIN;
          end
        end else begin
          op        = lba_pkg::OP_SCAN_RD;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        op = lba_pkg::OP_SCAN_CHK;
        if (!sts.match) begin
          state_nxt = S_FIND;
        end else if (sts.func == lba_pkg::FN_CREATE) begin
          st_nxt    = lba_pkg::ST_EXISTS;
          state_nxt = S_FIN;
        end else if (sts.func == lba_pkg::FN_DELETE) begin
          state_nxt = S_WALK0;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_CREATE: begin
        priority if (sts.full) begin
          st_nxt    = lba_pkg::ST_FULL;
          state_nxt = S_FIN;
        end else if (sts.short_blk) begin
          st_nxt    = lba_pkg::ST_SHORT;
          state_nxt = S_FIN;
        end else begin
          op        = lba_pkg::OP_ALLOC_INIT;
          state_nxt = S_ALLOC;
        end
      end
      S_APPEND: begin
        priority if (sts.cnt_zero) begin
          state_nxt = S_FIN;
        end else if (sts.short_blk) begin
          st_nxt    = lba_pkg::ST_SHORT;
          state_nxt = S_FIN;
        end else begin
          op        = lba_pkg::OP_ALLOC_INIT;
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (sts.alloc_done) begin
          op        = lba_pkg::OP_ALLOC_END;
          state_nxt = S_ALLOC_WR;
        end else begin
          op = lba_pkg::OP_ALLOC_STEP;
        end
      end
      S_ALLOC_WR: begin
        op = (sts.func == lba_pkg::FN_CREATE) ? lba_pkg::OP_CREATE_WR
                                               : lba_pkg::OP_APPEND_WR;
        state_nxt = S_FIN;
      end
      S_WALK0: begin
        op        = lba_pkg::OP_WALK_INIT;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) begin
          op        = lba_pkg::OP_WALK_END;
          state_nxt = S_SHIFT;
        end else begin
          op        = lba_pkg::OP_WALK_RD;
          state_nxt = S_WALK_NXT;
        end
      end
      S_WALK_NXT: begin
        op        = lba_pkg::OP_WALK_NXT;
        state_nxt = S_WALK;
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          op        = lba_pkg::OP_DEL_END;
          state_nxt = S_FIN;
        end else begin
          op        = lba_pkg::OP_SHIFT_RD;
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        op        = lba_pkg::OP_SHIFT_WR;
        state_nxt = S_SHIFT;
      end
      S_PACK: begin
        if (sts.scan_end) begin
          state_nxt = S_FIN;
        end else begin
          op        = lba_pkg::OP_SCAN_RD;
          state_nxt = S_PACK_CAP;
        end
      end
      S_PACK_CAP: begin
        op        = lba_pkg::OP_PACK_CAP;
        state_nxt = S_PACK_FIT;
      end
      S_PACK_FIT: begin
        if (sts.pack_fit) begin
          state_nxt = S_PACK_BLK;
        end else begin
          op        = lba_pkg::OP_PACK_SKIP;
          state_nxt = S_PACK;
        end
      end
      S_PACK_BLK: begin
        if (sts.pack_blk_done) begin
          op        = lba_pkg::OP_PACK_WR;
          state_nxt = S_PACK;
        end else begin
          op = lba_pkg::OP_PACK_STEP;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          op        = lba_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      S_FIN_SLOT: begin
        if (sts.out_free) begin
          op        = lba_pkg::OP_FINISH_SLOT;
          state_nxt = S_IDLE;
        end
      end
      S_FIN_LINK: begin
        if (sts.out_free) begin
          op        = lba_pkg::OP_FINISH_LINK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= lba_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd.op   = op;
  assign cmd.st   = st_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer taken while a command is in progress");

endmodule
